// ----- rtl/pppf_pkg.sv -----
`default_nettype none
package pppf_pkg;

	localparam logic [7:0] FLAG_BYTE  = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ADDR_BYTE  = 8'hFF;
	localparam logic [7:0] CTRL_BYTE  = 8'h03;
	localparam logic [7:0] CHECK_BYTE = 8'h00;
	localparam logic [15:0] PROTO_RESET = 16'h0021;

	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_payload;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       frame_done;
	} out_item_t;

	// Classified work for the back end: one entry per non-idle transaction.
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       eop;
		logic       esc;
		logic       hdr;
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FLAG,
		ST_ADDR,
		ST_CTRL,
		ST_PROTO_HI,
		ST_PROTO_LO,
		ST_ESC,
		ST_DATA,
		ST_CHECK,
		ST_CLOSE
	} step_t;

endpackage
`default_nettype wire

// ----- rtl/pppf_front.sv -----
`default_nettype none
module pppf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire pppf_pkg::in_item_t in_item,
	input  wire logic              q_full,
	output logic                   q_push,
	output pppf_pkg::cmd_t         q_cmd
);

	logic frame_open_q;
	logic accept;
	logic active;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	// A transaction with neither a byte nor a close does nothing at all.
	assign active   = in_item.has_byte || in_item.end_of_payload;
	assign q_push   = accept && active;

	always_comb begin
		q_cmd.data_byte = in_item.data_byte;
		q_cmd.has_byte  = in_item.has_byte;
		q_cmd.eop       = in_item.end_of_payload;
		q_cmd.esc       = (in_item.data_byte == pppf_pkg::FLAG_BYTE) ||
		                  (in_item.data_byte == pppf_pkg::ESC_BYTE);
		q_cmd.hdr       = !frame_open_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
		end else if (q_push) begin
			frame_open_q <= !in_item.end_of_payload;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pppf_queue.sv -----
`default_nettype none
module pppf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pppf_pkg::cmd_t  push_cmd,
	input  wire logic            pop,
	output logic                 full,
	output logic                 head_valid,
	output pppf_pkg::cmd_t       head_cmd
);

	pppf_pkg::cmd_t           mem [pppf_pkg::QDEPTH];
	logic [pppf_pkg::QAW-1:0] wr_ptr_q;
	logic [pppf_pkg::QAW-1:0] rd_ptr_q;
	logic [pppf_pkg::QAW:0]   count_q;

	assign full       = (count_q == (pppf_pkg::QAW+1)'(pppf_pkg::QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/pppf_back.sv -----
`default_nettype none
module pppf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              head_valid,
	input  wire pppf_pkg::cmd_t    head_cmd,
	output logic                   pop,
	input  wire logic [15:0]       protocol_id,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output pppf_pkg::out_item_t    out_item
);

	pppf_pkg::step_t     step_q;
	pppf_pkg::step_t     step_d;
	pppf_pkg::step_t     cur;
	pppf_pkg::step_t     nxt;
	logic                out_valid_q;
	pppf_pkg::out_item_t out_item_q;
	pppf_pkg::out_item_t emit;
	logic                load;
	logic                run_end;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;
	assign load      = head_valid && (!out_valid_q || !out_stall);
	assign pop       = load && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= pppf_pkg::ST_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

	always_comb begin
		// At the start of a transaction the first step comes from its class.
		if (step_q == pppf_pkg::ST_IDLE) begin
			if (head_cmd.hdr) begin
				cur = pppf_pkg::ST_FLAG;
			end else if (head_cmd.has_byte) begin
				cur = head_cmd.esc ? pppf_pkg::ST_ESC : pppf_pkg::ST_DATA;
			end else begin
				cur = pppf_pkg::ST_CHECK;
			end
		end else begin
			cur = step_q;
		end

		nxt     = pppf_pkg::ST_IDLE;
		run_end = 1'b0;
		emit    = '0;
		unique case (cur)
			pppf_pkg::ST_FLAG: begin
				emit.out_byte = pppf_pkg::FLAG_BYTE;
				nxt           = pppf_pkg::ST_ADDR;
			end
			pppf_pkg::ST_ADDR: begin
				emit.out_byte = pppf_pkg::ADDR_BYTE;
				nxt           = pppf_pkg::ST_CTRL;
			end
			pppf_pkg::ST_CTRL: begin
				emit.out_byte = pppf_pkg::CTRL_BYTE;
				nxt           = pppf_pkg::ST_PROTO_HI;
			end
			pppf_pkg::ST_PROTO_HI: begin
				emit.out_byte = protocol_id[15:8];
				nxt           = pppf_pkg::ST_PROTO_LO;
			end
			pppf_pkg::ST_PROTO_LO: begin
				emit.out_byte = protocol_id[7:0];
				if (head_cmd.has_byte) begin
					nxt = head_cmd.esc ? pppf_pkg::ST_ESC : pppf_pkg::ST_DATA;
				end else begin
					nxt = pppf_pkg::ST_CHECK;
				end
			end
			pppf_pkg::ST_ESC: begin
				emit.out_byte = pppf_pkg::ESC_BYTE;
				nxt           = pppf_pkg::ST_DATA;
			end
			pppf_pkg::ST_DATA: begin
				emit.out_byte = head_cmd.data_byte;
				if (head_cmd.eop) begin
					nxt = pppf_pkg::ST_CHECK;
				end else begin
					run_end = 1'b1;
				end
			end
			pppf_pkg::ST_CHECK: begin
				emit.out_byte = pppf_pkg::CHECK_BYTE;
				nxt           = pppf_pkg::ST_CLOSE;
			end
			pppf_pkg::ST_CLOSE: begin
				emit.out_byte   = pppf_pkg::FLAG_BYTE;
				emit.frame_done = 1'b1;
				run_end         = 1'b1;
			end
			default: begin
				run_end = 1'b1;
			end
		endcase
		emit.last_of_run = run_end;

		step_d = step_q;
		if (load) begin
			step_d = run_end ? pppf_pkg::ST_IDLE : nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= head_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_item_q <= emit;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/ppp_byte_stuffing_framer.sv -----
// Channel  | Direction | Handshake           | Payload
// in       | input     | in_valid / in_stall | in_item  (data_byte, has_byte, end_of_payload)
// out      | output    | out_valid/out_stall | out_item (out_byte, last_of_run, frame_done)
// cfg      | input     | cfg_we              | cfg_wdata (protocol_id)
//
// The output sequencer sends one byte per clock unless out_stall or an empty queue holds it.
// A plain payload byte gives one output byte, an escaped byte two; frame opening and closing
// add five and two bytes. A four-entry command queue separates input classification from
// byte sequencing. Reset clears the queue, the frame-open flag and the output register;
// protocol_id returns to 0x0021. in_stall rises only when the queue is full.
`default_nettype none
module ppp_byte_stuffing_framer (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire pppf_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output pppf_pkg::out_item_t      out_item,
	input  wire logic                cfg_we,
	input  wire logic [15:0]         cfg_wdata
);

	logic [15:0]    protocol_id_q;
	logic           q_full;
	logic           q_push;
	logic           q_pop;
	logic           head_valid;
	pppf_pkg::cmd_t push_cmd;
	pppf_pkg::cmd_t head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			protocol_id_q <= pppf_pkg::PROTO_RESET;
		end else if (cfg_we) begin
			protocol_id_q <= cfg_wdata;
		end
	end

	pppf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd)
	);

	pppf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.pop        (q_pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	pppf_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_cmd    (head_cmd),
		.pop         (q_pop),
		.protocol_id (protocol_id_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_item    (out_item)
	);

endmodule
`default_nettype wire

// ----- rtl/pppf_checker.sv -----
`default_nettype none
module pppf_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_stall,
	input wire pppf_pkg::out_item_t out_item
);

	// A closing flag always ends the run of its transaction.
	a_done_is_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_done |->
			(out_item.out_byte == pppf_pkg::FLAG_BYTE) && out_item.last_of_run)
		else $error("frame_done on a byte other than the final closing flag");

	// Every offered output transaction carries fully known bits.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_item))
		else $error("output transaction with unknown bits");

	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled output transaction changed");

endmodule

bind ppp_byte_stuffing_framer pppf_checker u_pppf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
`default_nettype wire
